>>> design/rwlt_pkg.sv
`timescale 1ns / 1ps

package rwlt_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned WORD_W        = 1 + COUNT_BITS + KEY_W;

  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  localparam logic       MODE_ACQUIRE = 1'b0;
  localparam logic       MODE_RELEASE = 1'b1;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;
  localparam logic [1:0] ACC_BOTH  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CONFLICT  = 3'd1,
    ST_FULL      = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_NOACCESS  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic             mode;
    logic [1:0]       access;
    logic [KEY_W-1:0] id;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [COUNT_BITS-1:0] cnt;
    logic                  wr;
    logic                  free;
    logic [IDX_W-1:0]      free_idx;
  } scan_t;

  typedef struct packed {
    status_e               status;
    logic                  granted;
    logic                  we;
    logic                  set_valid;
    logic                  clr_valid;
    logic [IDX_W-1:0]      idx;
    logic [COUNT_BITS-1:0] cnt;
    logic                  wr;
  } upd_t;

endpackage

>>> design/rwlt_ram.sv
`timescale 1ns / 1ps

module rwlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rwlt_update.sv
`timescale 1ns / 1ps

module rwlt_update (
  input  rwlt_pkg::req_t  req_i,
  input  rwlt_pkg::scan_t scan_i,
  output rwlt_pkg::upd_t  upd_o
);

  logic [rwlt_pkg::COUNT_BITS-1:0] cnt_inc;
  logic [rwlt_pkg::COUNT_BITS-1:0] cnt_dec;
  logic                            cnt_zero;
  logic                            cnt_one;

  assign cnt_inc  = scan_i.cnt + rwlt_pkg::COUNT_BITS'(req_i.access[0]);
  assign cnt_dec  = scan_i.cnt - rwlt_pkg::COUNT_ONE;
  assign cnt_zero = (scan_i.cnt == '0);
  assign cnt_one  = (scan_i.cnt == rwlt_pkg::COUNT_ONE);

  always_comb begin
    upd_o.status    = rwlt_pkg::ST_OK;
    upd_o.granted   = 1'b0;
    upd_o.we        = 1'b0;
    upd_o.set_valid = 1'b0;
    upd_o.clr_valid = 1'b0;
    upd_o.idx       = scan_i.hit ? scan_i.hit_idx : scan_i.free_idx;
    upd_o.cnt       = scan_i.cnt;
    upd_o.wr        = scan_i.wr;

    if (req_i.access == rwlt_pkg::ACC_NONE) begin
      upd_o.status = rwlt_pkg::ST_NOACCESS;
    end else if (req_i.mode == rwlt_pkg::MODE_ACQUIRE) begin
      if (scan_i.hit) begin
        if (scan_i.wr) begin
          upd_o.status = rwlt_pkg::ST_CONFLICT;
        end else if (req_i.access != rwlt_pkg::ACC_READ && !cnt_zero) begin
          upd_o.status = rwlt_pkg::ST_CONFLICT;
        end else if (req_i.access == rwlt_pkg::ACC_READ &&
                     scan_i.cnt == rwlt_pkg::COUNT_MAX) begin
          upd_o.status = rwlt_pkg::ST_OVERFLOW;
        end else begin
          upd_o.granted = 1'b1;
          upd_o.we      = 1'b1;
          upd_o.cnt     = cnt_inc;
          upd_o.wr      = scan_i.wr | req_i.access[1];
        end
      end else if (!scan_i.free) begin
        upd_o.status = rwlt_pkg::ST_FULL;
      end else begin
        upd_o.granted   = 1'b1;
        upd_o.we        = 1'b1;
        upd_o.set_valid = 1'b1;
        upd_o.cnt       = rwlt_pkg::COUNT_BITS'(req_i.access[0]);
        upd_o.wr        = req_i.access[1];
      end
    end else begin
      unique case (req_i.access)
        rwlt_pkg::ACC_READ: begin
          if (!scan_i.hit || cnt_zero) begin
            upd_o.status = rwlt_pkg::ST_UNDERFLOW;
          end else begin
            upd_o.we        = 1'b1;
            upd_o.cnt       = cnt_dec;
            upd_o.clr_valid = cnt_one && !scan_i.wr;
          end
        end
        rwlt_pkg::ACC_WRITE: begin
          if (scan_i.hit) begin
            upd_o.we        = 1'b1;
            upd_o.wr        = 1'b0;
            upd_o.clr_valid = cnt_zero;
          end
        end
        default: begin
          if (!scan_i.hit) begin
            upd_o.status = rwlt_pkg::ST_UNDERFLOW;
          end else begin
            upd_o.we = 1'b1;
            upd_o.wr = 1'b0;
            if (cnt_zero) begin
              upd_o.status    = rwlt_pkg::ST_UNDERFLOW;
              upd_o.clr_valid = 1'b1;
            end else begin
              upd_o.cnt       = cnt_dec;
              upd_o.clr_valid = cnt_one;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> design/rwlt_ctrl.sv
`timescale 1ns / 1ps

module rwlt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [1:0]                   access_i,
  input  logic [rwlt_pkg::KEY_W-1:0]   object_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         granted_o,
  output logic [2:0]                   status_o,
  output logic                         ram_re_o,
  output logic [rwlt_pkg::IDX_W-1:0]   ram_raddr_o,
  input  logic [rwlt_pkg::WORD_W-1:0]  ram_rdata_i,
  output logic                         ram_we_o,
  output logic [rwlt_pkg::IDX_W-1:0]   ram_waddr_o,
  output logic [rwlt_pkg::WORD_W-1:0]  ram_wdata_o,
  output rwlt_pkg::req_t               req_o,
  output rwlt_pkg::scan_t              scan_o,
  input  rwlt_pkg::upd_t               upd_i
);

  rwlt_pkg::state_e state_q, state_d;
  rwlt_pkg::req_t   req_q;
  rwlt_pkg::scan_t  scan_q;

  logic [rwlt_pkg::IDX_W-1:0]         addr_q;
  logic [rwlt_pkg::IDX_W-1:0]         cmp_idx_q;
  logic                               cmp_vld_q;
  logic [rwlt_pkg::TABLE_ENTRIES-1:0] valid_q;
  logic                               out_valid_q;
  logic                               granted_q;
  logic [2:0]                         status_q;

  logic                               in_fire;
  logic                               load_out;
  logic                               match;
  logic                               cmp_last;
  logic [rwlt_pkg::KEY_W-1:0]         rd_key;
  logic [rwlt_pkg::COUNT_BITS-1:0]    rd_cnt;
  logic                               rd_wr;

  assign rd_key = ram_rdata_i[rwlt_pkg::KEY_W-1:0];
  assign rd_cnt = ram_rdata_i[rwlt_pkg::KEY_W +: rwlt_pkg::COUNT_BITS];
  assign rd_wr  = ram_rdata_i[rwlt_pkg::WORD_W-1];

  assign in_ready_o = (state_q == rwlt_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_out   = (state_q == rwlt_pkg::S_EXEC) && (!out_valid_q || out_ready_i);
  assign match      = cmp_vld_q && valid_q[cmp_idx_q] && (rd_key == req_q.id);
  assign cmp_last   = (cmp_idx_q == rwlt_pkg::LAST_IDX);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rwlt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (access_i == rwlt_pkg::ACC_NONE) ? rwlt_pkg::S_EXEC : rwlt_pkg::S_SCAN;
        end
      end
      rwlt_pkg::S_SCAN: begin
        if (cmp_vld_q && (match || cmp_last)) begin
          state_d = rwlt_pkg::S_EXEC;
        end
      end
      rwlt_pkg::S_EXEC: begin
        if (load_out) begin
          state_d = rwlt_pkg::S_IDLE;
        end
      end
      default: state_d = rwlt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rwlt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.mode   <= mode_i;
      req_q.access <= access_i;
      req_q.id     <= object_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
    end else if (in_fire) begin
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= (state_q == rwlt_pkg::S_SCAN) && (state_d == rwlt_pkg::S_SCAN);
      if (state_q == rwlt_pkg::S_SCAN) begin
        cmp_idx_q <= addr_q;
        if (addr_q != rwlt_pkg::LAST_IDX) begin
          addr_q <= addr_q + rwlt_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (in_fire) begin
      scan_q.hit  <= 1'b0;
      scan_q.free <= 1'b0;
    end else if (state_q == rwlt_pkg::S_SCAN && cmp_vld_q) begin
      if (match) begin
        scan_q.hit     <= 1'b1;
        scan_q.hit_idx <= cmp_idx_q;
        scan_q.cnt     <= rd_cnt;
        scan_q.wr      <= rd_wr;
      end
      if (!valid_q[cmp_idx_q] && !scan_q.free) begin
        scan_q.free     <= 1'b1;
        scan_q.free_idx <= cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (load_out) begin
      if (upd_i.set_valid) begin
        valid_q[upd_i.idx] <= 1'b1;
      end
      if (upd_i.clr_valid) begin
        valid_q[upd_i.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      granted_q <= upd_i.granted;
      status_q  <= upd_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign status_o    = status_q;

  assign ram_re_o    = (state_q == rwlt_pkg::S_SCAN);
  assign ram_raddr_o = addr_q;
  assign ram_we_o    = load_out && upd_i.we;
  assign ram_waddr_o = upd_i.idx;
  assign ram_wdata_o = {upd_i.wr, upd_i.cnt, req_q.id};

  assign req_o  = req_q;
  assign scan_o = scan_q;

  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rwlt_pkg::S_EXEC && scan_q.hit) |-> valid_q[scan_q.hit_idx])
    else $error("matched entry is not valid at update");

  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rwlt_pkg::S_EXEC && !scan_q.hit && scan_q.free)
      |-> !valid_q[scan_q.free_idx])
    else $error("free entry is already valid at update");

  a_set_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(upd_i.set_valid && upd_i.clr_valid))
    else $error("entry allocated and freed in one update");

  a_cmp_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == rwlt_pkg::S_SCAN))
    else $error("compare stage active outside of scan");

  a_alloc_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && upd_i.set_valid) |=> valid_q[$past(upd_i.idx)])
    else $error("allocated entry did not become valid");

endmodule

>>> design/reader_writer_lock_table.sv
`timescale 1ns / 1ps

// Keyed reader-writer lock table.
// Input channel (in_valid_i / in_ready_o) carries one request: mode_i
// (acquire or release), access_i (none, read, write, both) and object_id_i.
// Output channel (out_valid_o / out_ready_i) returns one result per request:
// granted_o and status_o (ok, conflict, table full, count overflow,
// release underflow, no access).
// A request walks the key table one entry per cycle through a single key
// comparator reading the entry RAM. The walk ends at the first matching
// entry or after the last entry; access none skips it. One request is in
// flight at a time; in_ready_o rises together with out_valid_o as the
// result is loaded, so a new request is accepted only once the last ends.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; a stalled receiver holds the block at its
// update step until the output register frees up.
// Reset clears all entry valid bits, which empties the table at once; no
// clearing pass is needed.

module reader_writer_lock_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [1:0]                 access_i,
  input  logic [rwlt_pkg::KEY_W-1:0] object_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       granted_o,
  output logic [2:0]                 status_o
);

  logic                        ram_re;
  logic [rwlt_pkg::IDX_W-1:0]  ram_raddr;
  logic [rwlt_pkg::WORD_W-1:0] ram_rdata;
  logic                        ram_we;
  logic [rwlt_pkg::IDX_W-1:0]  ram_waddr;
  logic [rwlt_pkg::WORD_W-1:0] ram_wdata;
  rwlt_pkg::req_t              req;
  rwlt_pkg::scan_t             scan;
  rwlt_pkg::upd_t              upd;

  rwlt_ram #(
    .WIDTH (rwlt_pkg::WORD_W),
    .DEPTH (rwlt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rwlt_update u_update (
    .req_i  (req),
    .scan_i (scan),
    .upd_o  (upd)
  );

  rwlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .access_i    (access_i),
    .object_id_i (object_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .granted_o   (granted_o),
    .status_o    (status_o),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .req_o       (req),
    .scan_o      (scan),
    .upd_i       (upd)
  );

endmodule
